// ===== rtl/lgs_pkg.sv =====
package lgs_pkg;

  // Opcodes of a command transaction.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 2'd1;

  // Width of the size registers.
  localparam int unsigned SIZE_W = 7;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] row_index;
    logic [5:0] col_index;
    logic       write_value;
  } cmd_t;

  typedef struct packed {
    logic read_value;
    logic index_error;
  } rsp_t;

endpackage

// ===== rtl/life_generation_step.sv =====
// A read or write is accepted in S_IDLE, which reads its row; S_ACCESS applies it and S_HOLD queues the response
// transaction. An out-of-range access, an unused opcode or a step on an empty grid goes from S_IDLE to S_HOLD.
// A generation step sweeps the rows in S_SWEEP, with the grid memory's single row read per cycle, then goes to S_HOLD.
// One command at a time; the next is taken once the response is queued.
// Reset (rst, synchronous) restores 64 rows and 64 columns and then clears the grid memory
// row by row, during which no command is accepted; configuration writes still are.
module life_generation_step
  import lgs_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  // Command channel.
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  cmd_t                   cmd,
  // Response channel.
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_t                   rsp,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  // Row address width, and the width of a row count that can reach MAX_ROWS itself.
  localparam int unsigned AW   = $clog2(MAX_ROWS);
  localparam int unsigned NRW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CIW  = $clog2(MAX_COLS);
  localparam int unsigned CNTW = (NRW > SIZE_W) ? NRW : SIZE_W;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ACCESS = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_HOLD   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [SIZE_W-1:0] row_count;
  logic [SIZE_W-1:0] col_count;

  // The grid: one word of MAX_COLS cells per row.
  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [MAX_COLS-1:0] wr_data;

  // Registers of the command in flight.
  logic [1:0]          op_q;
  logic [AW-1:0]       row_q;
  logic [CIW-1:0]      col_q;
  logic                val_q;
  rsp_t                res;
  rsp_t                res_next;

  // Sweep state: the row whose old word sits in rdata, and the two rows above it.
  logic [NRW-1:0]      row;
  logic [NRW-1:0]      row_inc;
  logic [MAX_COLS-1:0] above;
  logic [MAX_COLS-1:0] mid;
  logic [AW-1:0]       clr_row;

  logic                cmd_fire;
  logic                rsp_free;
  logic [CNTW-1:0]     rows_ext;
  logic [CNTW-1:0]     rows_eff;
  logic [NRW-1:0]      nr;
  logic [SIZE_W-1:0]   nc;
  logic [MAX_COLS-1:0] colmask;
  logic                in_range;
  logic [MAX_COLS-1:0] below_m;
  logic [MAX_COLS-1:0] new_word;
  logic [MAX_COLS-1:0] cell_bit;

  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign row_inc   = row + 1'b1;

  // Sizes above the maximum act as the maximum.
  assign rows_ext = CNTW'(row_count);
  assign rows_eff = (rows_ext > CNTW'(MAX_ROWS)) ? CNTW'(MAX_ROWS) : rows_ext;
  assign nr       = rows_eff[NRW-1:0];
  assign nc       = (col_count > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : col_count;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      colmask[c] = (SIZE_W'(c) < nc);
    end
  end

  assign in_range = (CNTW'(cmd.row_index) < CNTW'(nr)) &&
                    (SIZE_W'(cmd.col_index) < nc);

  // The row below the one being updated; past the last row in use it is all dead.
  assign below_m = (row < nr) ? (rdata & colmask) : '0;

  // Rule B3/S23 across one row word. Columns beyond the size keep their old value.
  always_comb begin
    logic [MAX_COLS+1:0] ap;
    logic [MAX_COLS+1:0] mp;
    logic [MAX_COLS+1:0] bp;
    logic [3:0]          n;
    ap = {1'b0, above & colmask, 1'b0};
    mp = {1'b0, mid & colmask, 1'b0};
    bp = {1'b0, below_m, 1'b0};
    for (int c = 0; c < MAX_COLS; c++) begin
      n = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2]) + 4'(mp[c]) + 4'(mp[c+2]) +
          4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
      if (colmask[c]) begin
        new_word[c] = (n == 4'd3) || ((n == 4'd2) && mid[c]);
      end else begin
        new_word[c] = mid[c];
      end
    end
  end

  assign cell_bit = MAX_COLS'(1) << col_q;

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_row;
      end
      S_IDLE: begin
        if (cmd_fire) begin
          rd_en   = 1'b1;
          rd_addr = (cmd.opcode == OP_STEP) ? '0 : AW'(cmd.row_index);
        end
      end
      S_ACCESS: begin
        if (op_q == OP_WRITE) begin
          wr_en   = 1'b1;
          wr_addr = row_q;
          wr_data = val_q ? (rdata | cell_bit) : (rdata & ~cell_bit);
        end
      end
      S_SWEEP: begin
        // Row r-1 is written back while row r+1 is read, so the two never meet.
        if (row != '0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(row - 1'b1);
          wr_data = new_word;
        end
        if (row_inc < nr) begin
          rd_en   = 1'b1;
          rd_addr = row_inc[AW-1:0];
        end
      end
      S_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= grid_mem[rd_addr];
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    res_next   = res;
    unique case (state)
      S_CLEAR: begin
        if (clr_row == AW'(MAX_ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_fire) begin
          res_next = '0;
          if (cmd.opcode == OP_WRITE || cmd.opcode == OP_READ) begin
            if (in_range) begin
              state_next = S_ACCESS;
            end else begin
              res_next.index_error = 1'b1;
              state_next           = S_HOLD;
            end
          end else if (cmd.opcode == OP_STEP && nr != '0) begin
            state_next = S_SWEEP;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_ACCESS: begin
        res_next.read_value = (op_q == OP_READ) ? rdata[col_q] : 1'b0;
        state_next          = S_HOLD;
      end
      S_SWEEP: begin
        if (row == nr) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      row       <= '0;
      rsp_valid <= 1'b0;
      row_count <= SIZE_W'(64);
      col_count <= SIZE_W'(64);
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_row <= clr_row + 1'b1;
      end
      if (state == S_IDLE) begin
        row <= '0;
      end else if (state == S_SWEEP) begin
        row <= row_inc;
      end
      // A new response may replace the one taken at this same edge.
      if (state == S_HOLD && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROW_COUNT) begin
          row_count <= cfg_data;
        end else if (cfg_index == REG_COL_COUNT) begin
          col_count <= cfg_data;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    res <= res_next;
    if (cmd_fire) begin
      op_q  <= cmd.opcode;
      row_q <= AW'(cmd.row_index);
      col_q <= CIW'(cmd.col_index);
      val_q <= cmd.write_value;
      above <= '0;
      mid   <= '0;
    end else if (state == S_SWEEP) begin
      above <= mid;
      mid   <= rdata;
    end
    if (state == S_HOLD && rsp_free) begin
      rsp <= res;
    end
  end

  a_no_cmd_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> cmd_stall)
    else $error("command accepted during grid clear");

  a_rsp_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.read_value && rsp.index_error))
    else $error("read value and index error both set");

  a_rsp_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_HOLD))
    else $error("response raised outside the hold state");

  a_sweep_ports_apart: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("sweep reads and writes the same row");

endmodule
